// ===== design/asw_pkg.sv =====
// Shared types and constants for the aliased store watchpoint.
// No dependencies; used by every module in this folder.
`timescale 1ns / 1ps

package asw_pkg;

	localparam int ADDR_W      = 32;
	localparam int MIRROR_BITS = 28;
	localparam int CFG_IDX_W   = 3;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_BLOCK = 1'b1;

	localparam logic [ADDR_W:0] ADDR_LIMIT = {1'b1, {ADDR_W{1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIRROR_ENABLE,
		REG_TILE_BASE,
		REG_HEAP_BASE,
		REG_HEAP_OFFSET,
		REG_HEAP_SPAN,
		REG_WATCH_START,
		REG_WATCH_BYTES,
		REG_RAW_MODE
	} cfg_reg_t;

	typedef struct packed {
		logic [MIRROR_BITS-1:0] mirror_enable;
		logic [ADDR_W-1:0]      tile_base;
		logic [ADDR_W:0]        tile_end;
		logic [ADDR_W-1:0]      heap_base;
		logic [ADDR_W-1:0]      heap_offset;
		logic [ADDR_W-1:0]      heap_span;
		logic [ADDR_W:0]        heap_end;
		logic [ADDR_W-1:0]      watch_start;
		logic [ADDR_W-1:0]      watch_bytes;
		logic [ADDR_W:0]        watch_end;
		logic                   raw_mode;
	} cfg_t;

	typedef struct packed {
		logic              norm;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] add;
	} win_t;

endpackage

// ===== design/asw_cfg_regs.sv =====
// Configuration register file with precomputed window and watch end bounds.
// Depends on asw_pkg.
`timescale 1ns / 1ps

module asw_cfg_regs #(
	parameter longint TILE_BYTES = 67108864
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [asw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [asw_pkg::ADDR_W-1:0]       cfg_data,
	output asw_pkg::cfg_t                    cfg
);

	localparam logic [asw_pkg::ADDR_W:0] TILE_BYTES_W = (asw_pkg::ADDR_W + 1)'(TILE_BYTES);
	localparam asw_pkg::cfg_t CFG_RESET = '{tile_end: TILE_BYTES_W, default: '0};

	asw_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (asw_pkg::cfg_reg_t'(cfg_index))
				asw_pkg::REG_MIRROR_ENABLE: begin
					cfg_q.mirror_enable <= cfg_data[asw_pkg::MIRROR_BITS-1:0];
				end
				asw_pkg::REG_TILE_BASE: begin
					cfg_q.tile_base <= cfg_data;
					cfg_q.tile_end  <= {1'b0, cfg_data} + TILE_BYTES_W;
				end
				asw_pkg::REG_HEAP_BASE: begin
					cfg_q.heap_base <= cfg_data;
					cfg_q.heap_end  <= {1'b0, cfg_data} + {1'b0, cfg_q.heap_span};
				end
				asw_pkg::REG_HEAP_OFFSET: begin
					cfg_q.heap_offset <= cfg_data;
				end
				asw_pkg::REG_HEAP_SPAN: begin
					cfg_q.heap_span <= cfg_data;
					cfg_q.heap_end  <= {1'b0, cfg_q.heap_base} + {1'b0, cfg_data};
				end
				asw_pkg::REG_WATCH_START: begin
					cfg_q.watch_start <= cfg_data;
					cfg_q.watch_end   <= {1'b0, cfg_data} + {1'b0, cfg_q.watch_bytes};
				end
				asw_pkg::REG_WATCH_BYTES: begin
					cfg_q.watch_bytes <= cfg_data;
					cfg_q.watch_end   <= {1'b0, cfg_q.watch_start} + {1'b0, cfg_data};
				end
				asw_pkg::REG_RAW_MODE: begin
					cfg_q.raw_mode <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== design/asw_window.sv =====
// Alias window match: direct RAM, mirrors, tiled view, heap view, in priority order.
// Depends on asw_pkg; purely combinational, all windows compared in parallel.
`timescale 1ns / 1ps

module asw_window #(
	parameter longint RAM_BYTES    = 67108864,
	parameter int     MIRROR_COUNT = 28,
	parameter longint TILE_BYTES   = 67108864
) (
	input  logic                         try_en,
	input  logic [asw_pkg::ADDR_W-1:0]   va,
	input  logic [asw_pkg::ADDR_W:0]     va_end,
	input  logic [asw_pkg::ADDR_W:0]     len,
	input  asw_pkg::cfg_t                cfg,
	output asw_pkg::win_t                win
);

	localparam int BW = asw_pkg::ADDR_W + 2;
	localparam logic [BW-1:0] SPAN_W = BW'(RAM_BYTES);

	logic [31:0]   en_ext;
	logic [BW-1:0] va_x;
	logic [BW-1:0] end_x;
	logic          ok;

	assign en_ext = 32'(cfg.mirror_enable);
	assign va_x   = BW'(va);
	assign end_x  = BW'(va_end);
	assign ok     = try_en && (len != '0) && (va_end <= asw_pkg::ADDR_LIMIT);

	always_comb begin
		logic [BW-1:0] m_lo;
		logic [BW-1:0] m_hi;
		win  = '0;
		m_lo = '0;
		m_hi = '0;
		if (cfg.heap_span != '0 && va >= cfg.heap_base && va_end <= cfg.heap_end) begin
			win.norm = 1'b1;
			win.base = cfg.heap_base;
			win.add  = cfg.heap_offset;
		end
		if (TILE_BYTES != 0 && va >= cfg.tile_base && va_end <= cfg.tile_end) begin
			win.norm = 1'b1;
			win.base = cfg.tile_base;
			win.add  = '0;
		end
		for (int i = MIRROR_COUNT - 1; i >= 0; i--) begin
			m_lo = BW'(longint'(i + 1) * RAM_BYTES);
			m_hi = m_lo + SPAN_W;
			if (en_ext[i[4:0]] && va_x >= m_lo && end_x <= m_hi) begin
				win.norm = 1'b1;
				win.base = m_lo[asw_pkg::ADDR_W-1:0];
				win.add  = '0;
			end
		end
		if (end_x <= SPAN_W) begin
			win.norm = 1'b1;
			win.base = '0;
			win.add  = '0;
		end
		if (!ok) begin
			win = '0;
		end
	end

endmodule

// ===== design/aliased_store_watchpoint.sv =====
// Aliased store watchpoint: four-register pipeline, one word accepted per cycle unless stalled.
// Path: a word accepted into stage 1 moves through stages 2 and 3 into the output register.
// Throughput: one word per cycle; stall propagates back through the stages.
// Reset clears all stage valids and the configuration registers (all zero but tile_end = TILE_BYTES).
// Configuration writes are registered when accepted; cfg_ready is held high.
// Depends on asw_pkg, asw_cfg_regs, asw_window.
`timescale 1ns / 1ps

module aliased_store_watchpoint #(
	parameter longint RAM_BYTES    = 67108864,
	parameter int     MIRROR_COUNT = 28,
	parameter longint TILE_BYTES   = 67108864
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [asw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [31:0]                   address,
	input  logic [3:0]                    access_bytes,
	input  logic [31:0]                   block_length,
	input  logic [31:0]                   writer_function,
	input  logic [31:0]                   writer_pc,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [31:0]                   compared_address,
	output logic                          was_normalized,
	output logic [31:0]                   span_low,
	output logic [32:0]                   span_high,
	output logic [31:0]                   hit_function,
	output logic [31:0]                   hit_pc
);

	asw_pkg::cfg_t cfg;
	asw_pkg::win_t win;

	asw_cfg_regs #(
		.TILE_BYTES(TILE_BYTES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic en1, en2, en3, en4;
	logic valid_s1, valid_s2, valid_s3, out_valid_q;

	assign en4      = !out_valid_q || !out_stall;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;

	// span setup
	logic        is_block, store_ok, blk_gt;
	logic [31:0] blk_lo, lo_d;
	logic [32:0] blk_hi, blk_len, st_len, st_hi, hi_d, len_d;

	always_comb begin
		is_block = (command == asw_pkg::CMD_BLOCK);
		store_ok = access_bytes inside {4'd1, 4'd2, 4'd4, 4'd8};
		blk_gt   = address > block_length;
		blk_lo   = blk_gt ? (address - block_length) : '0;
		blk_hi   = {1'b0, address} + {1'b0, block_length};
		blk_len  = blk_gt ? {block_length, 1'b0} : blk_hi;
		st_len   = store_ok ? 33'(access_bytes) : '0;
		st_hi    = {1'b0, address} + st_len;
		lo_d     = is_block ? blk_lo : address;
		hi_d     = is_block ? blk_hi : st_hi;
		len_d    = is_block ? blk_len : st_len;
	end

	logic        block_s1, try_s1, raw_s1;
	logic [31:0] lo_s1, fn_s1, pc_s1;
	logic [32:0] hi_s1, len_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			block_s1 <= is_block;
			try_s1   <= is_block || (store_ok && !cfg.raw_mode);
			raw_s1   <= !is_block && store_ok && cfg.raw_mode;
			lo_s1    <= lo_d;
			hi_s1    <= hi_d;
			len_s1   <= len_d;
			fn_s1    <= writer_function;
			pc_s1    <= writer_pc;
		end
	end

	asw_window #(
		.RAM_BYTES    (RAM_BYTES),
		.MIRROR_COUNT (MIRROR_COUNT),
		.TILE_BYTES   (TILE_BYTES)
	) u_window (
		.try_en (try_s1),
		.va     (lo_s1),
		.va_end (hi_s1),
		.len    (len_s1),
		.cfg    (cfg),
		.win    (win)
	);

	logic        block_s2, raw_s2, norm_s2;
	logic [31:0] lo_s2, base_s2, add_s2, fn_s2, pc_s2;
	logic [32:0] hi_s2, len_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			block_s2 <= block_s1;
			raw_s2   <= raw_s1;
			norm_s2  <= win.norm;
			base_s2  <= win.base;
			add_s2   <= win.add;
			lo_s2    <= lo_s1;
			hi_s2    <= hi_s1;
			len_s2   <= len_s1;
			fn_s2    <= fn_s1;
			pc_s2    <= pc_s1;
		end
	end

	logic [31:0] offset;
	assign offset = lo_s2 - base_s2 + add_s2;

	logic        st_norm_s3, norm_s3, can_hit_s3;
	logic [31:0] cmp_s3, lo_s3, fn_s3, pc_s3;
	logic [32:0] hi_s3, len_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			norm_s3    <= norm_s2;
			st_norm_s3 <= !block_s2 && norm_s2;
			can_hit_s3 <= block_s2 || raw_s2 || norm_s2;
			cmp_s3     <= norm_s2 ? offset : lo_s2;
			lo_s3      <= (!block_s2 && norm_s2) ? offset : lo_s2;
			hi_s3      <= hi_s2;
			len_s3     <= len_s2;
			fn_s3      <= fn_s2;
			pc_s3      <= pc_s2;
		end
	end

	// overlap against [watch_start, watch_end)
	logic [33:0] end_sum;
	logic        hit_d;

	assign end_sum = {2'b00, cmp_s3} + {1'b0, len_s3};
	assign hit_d   = can_hit_s3 && (cfg.watch_bytes != '0) && (len_s3 != '0)
		&& ({1'b0, cmp_s3} < cfg.watch_end)
		&& ({2'b00, cfg.watch_start} < end_sum);

	logic        hit_q, norm_q;
	logic [31:0] cmp_q, lo_q, fn_q, pc_q;
	logic [32:0] hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en4) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			hit_q  <= hit_d;
			norm_q <= norm_s3;
			cmp_q  <= cmp_s3;
			lo_q   <= lo_s3;
			hi_q   <= st_norm_s3 ? end_sum[32:0] : hi_s3;
			fn_q   <= fn_s3;
			pc_q   <= pc_s3;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = hit_q;
	assign compared_address = cmp_q;
	assign was_normalized   = norm_q;
	assign span_low         = lo_q;
	assign span_high        = hi_q;
	assign hit_function     = fn_q;
	assign hit_pc           = pc_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> cfg.watch_bytes != '0)
		else $error("hit reported with watch disarmed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> span_high > {1'b0, span_low})
		else $error("hit reported on empty span");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && out_valid_q && out_stall)
		else $error("input stalled with room in pipeline");

endmodule

// ===== bench/aliased_store_watchpoint_tb.sv =====
// Self-checking bench for aliased_store_watchpoint: directed and random store/block words,
// with a local alias-window predictor and an in-order scoreboard of expected reports.
// Depends on asw_pkg and the aliased_store_watchpoint RTL.
`timescale 1ns / 1ps

module aliased_store_watchpoint_tb;

	localparam longint RAM_BYTES    = 67108864;
	localparam int     MIRROR_COUNT = 28;
	localparam longint TILE_BYTES   = 67108864;
	localparam int     QUIET_LIMIT  = 2000;
	localparam int     LONG_HOLD    = 200;

	typedef struct packed {
		logic        command;
		logic [31:0] address;
		logic [3:0]  access_bytes;
		logic [31:0] block_length;
		logic [31:0] writer_function;
		logic [31:0] writer_pc;
	} write_word_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] compared_address;
		logic        was_normalized;
		logic [31:0] span_low;
		logic [32:0] span_high;
		logic [31:0] hit_function;
		logic [31:0] hit_pc;
	} report_t;

	typedef struct packed {
		logic [asw_pkg::MIRROR_BITS-1:0] mirror_en;
		logic [31:0]                     tile_base;
		logic [31:0]                     heap_base;
		logic [31:0]                     heap_offset;
		logic [31:0]                     heap_span;
		logic [31:0]                     watch_start;
		logic [31:0]                     watch_bytes;
		logic                            raw;
	} settings_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	asw_pkg::cfg_reg_t cfg_index = asw_pkg::REG_MIRROR_ENABLE;
	logic [31:0]       cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              command = asw_pkg::CMD_STORE;
	logic [31:0]       address = '0;
	logic [3:0]        access_bytes = '0;
	logic [31:0]       block_length = '0;
	logic [31:0]       writer_function = '0;
	logic [31:0]       writer_pc = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              hit;
	logic [31:0]       compared_address;
	logic              was_normalized;
	logic [31:0]       span_low;
	logic [32:0]       span_high;
	logic [31:0]       hit_function;
	logic [31:0]       hit_pc;

	settings_t   live = '0;
	write_word_t pending_writes[$];
	report_t     due_reports[$];
	write_word_t offered;
	report_t     want;
	int          issued = 0;
	int          taken_count = 0;
	int          seen_count = 0;
	int          faults = 0;
	int          send_gap = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	bit          jitter = 1'b1;
	bit          long_hold_done = 1'b0;

	aliased_store_watchpoint #(
		.RAM_BYTES(RAM_BYTES),
		.MIRROR_COUNT(MIRROR_COUNT),
		.TILE_BYTES(TILE_BYTES)
	) uut (.*);

	always #1 clk = ~clk;

	function automatic logic fits(input logic [63:0] va, fin, lo, hi);
		return va >= lo && fin <= hi;
	endfunction

	function automatic logic to_ram_offset(input logic [63:0] va, len, output logic [31:0] ofs);
		logic [63:0] fin, lo;
		int i;
		fin = va + len;
		ofs = '0;
		if (len == 0 || fin > 64'(asw_pkg::ADDR_LIMIT))
			return 1'b0;
		if (fits(va, fin, '0, 64'(RAM_BYTES))) begin
			ofs = va[31:0];
			return 1'b1;
		end
		for (i = 0; i < MIRROR_COUNT && i < asw_pkg::MIRROR_BITS; i++) begin
			lo = 64'(i + 1) * 64'(RAM_BYTES);
			if (live.mirror_en[i] && fits(va, fin, lo, lo + 64'(RAM_BYTES))) begin
				ofs = va[31:0] - lo[31:0];
				return 1'b1;
			end
		end
		lo = 64'(live.tile_base);
		if (TILE_BYTES != 0 && fits(va, fin, lo, lo + 64'(TILE_BYTES))) begin
			ofs = va[31:0] - live.tile_base;
			return 1'b1;
		end
		lo = 64'(live.heap_base);
		if (live.heap_span != 0 && fits(va, fin, lo, lo + 64'(live.heap_span))) begin
			ofs = live.heap_offset + (va[31:0] - live.heap_base);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic touches_watch(input logic [63:0] base, len);
		logic [63:0] w_lo, w_hi;
		w_lo = 64'(live.watch_start);
		w_hi = w_lo + 64'(live.watch_bytes);
		if (live.watch_bytes == 0 || len == 0)
			return 1'b0;
		return base < w_hi && w_lo < base + len;
	endfunction

	function automatic report_t judge_write(input write_word_t w);
		report_t     r;
		logic [63:0] addr, blen, wid, cmp, lo, hi;
		logic [31:0] ofs;
		logic        norm, touched;
		addr = 64'(w.address);
		blen = 64'(w.block_length);
		wid = 64'(w.access_bytes);
		cmp = addr;
		lo = addr;
		hi = addr;
		norm = 1'b0;
		touched = 1'b0;
		if (w.command == asw_pkg::CMD_STORE) begin
			if (wid == 1 || wid == 2 || wid == 4 || wid == 8) begin
				hi = addr + wid;
				if (live.raw) begin
					touched = touches_watch(addr, wid);
				end else if (to_ram_offset(addr, wid, ofs)) begin
					norm = 1'b1;
					cmp = 64'(ofs);
					lo = 64'(ofs);
					hi = lo + wid;
					touched = touches_watch(cmp, wid);
				end
			end
		end else begin
			// conservative span around the cursor, low end clamped at zero
			lo = addr > blen ? addr - blen : '0;
			hi = addr + blen;
			if (to_ram_offset(lo, hi - lo, ofs)) begin
				norm = 1'b1;
				cmp = 64'(ofs);
			end else begin
				cmp = lo;
			end
			touched = blen != 0 && touches_watch(cmp, hi - lo);
		end
		r.hit = touched;
		r.compared_address = cmp[31:0];
		r.was_normalized = norm;
		r.span_low = lo[31:0];
		r.span_high = hi[32:0];
		r.hit_function = w.writer_function;
		r.hit_pc = w.writer_pc;
		return r;
	endfunction

	function automatic write_word_t mk(input logic cmd, input logic [31:0] addr,
			input logic [3:0] wid, input logic [31:0] len);
		write_word_t w;
		w.command = cmd;
		w.address = addr;
		w.access_bytes = wid;
		w.block_length = len;
		w.writer_function = $urandom;
		w.writer_pc = $urandom;
		return w;
	endfunction

	function automatic write_word_t random_word();
		write_word_t w;
		logic [31:0] near;
		int k;
		near = live.watch_start + $urandom_range(0, 40) - 20;
		k = $urandom_range(0, asw_pkg::MIRROR_BITS - 1);
		w = mk($urandom_range(0, 9) < 6 ? asw_pkg::CMD_STORE : asw_pkg::CMD_BLOCK, '0, '0, '0);
		case ($urandom_range(0, 6))
			0: w.address = near;
			1: w.address = 32'((k + 1) * RAM_BYTES + near % RAM_BYTES);
			2: w.address = 32'(live.tile_base + near % TILE_BYTES);
			3: w.address = live.heap_base + (near - live.heap_offset);
			4: w.address = $urandom;
			5: begin
				case ($urandom_range(0, 3))
					0: w.address = 32'((k + 1) * RAM_BYTES);
					1: w.address = 32'(live.tile_base + TILE_BYTES);
					2: w.address = live.heap_base + live.heap_span;
					default: w.address = 32'd0;
				endcase
				w.address = w.address + $urandom_range(0, 16) - 8;
			end
			default: w.address = 32'hFFFF_FFFF - $urandom_range(0, 15);
		endcase
		if ($urandom_range(0, 7) == 0)
			w.access_bytes = 4'($urandom_range(0, 8));
		else
			w.access_bytes = 4'd1 << $urandom_range(0, 3);
		case ($urandom_range(0, 9))
			0: w.block_length = '0;
			7: w.block_length = $urandom_range(1, 1 << 20);
			8: w.block_length = $urandom;
			9: w.block_length = 32'hFFFF_FFFF - $urandom_range(0, 15);
			default: w.block_length = $urandom_range(1, 64);
		endcase
		return w;
	endfunction

	function automatic settings_t random_settings();
		settings_t   s;
		logic [31:0] bits;
		if ($urandom_range(0, 2) == 0)
			bits = 32'd1 << $urandom_range(0, asw_pkg::MIRROR_BITS - 1);
		else
			bits = $urandom;
		s.mirror_en = bits[asw_pkg::MIRROR_BITS-1:0];
		case ($urandom_range(0, 2))
			0: s.tile_base = $urandom;
			1: s.tile_base = $urandom_range(0, 63) * 32'h0400_0000;
			default: s.tile_base = 32'hFC00_0000;
		endcase
		s.heap_base = $urandom;
		s.heap_offset = $urandom_range(0, 1) ? $urandom_range(0, 32'(RAM_BYTES - 1)) : $urandom;
		case ($urandom_range(0, 3))
			0: s.heap_span = '0;
			1: s.heap_span = $urandom_range(1, 4096);
			2: s.heap_span = $urandom_range(1, 1 << 24);
			default: s.heap_span = $urandom;
		endcase
		s.watch_start = $urandom_range(0, 3) != 0 ? $urandom_range(0, 32'(RAM_BYTES - 1))
			: $urandom;
		case ($urandom_range(0, 4))
			0: s.watch_bytes = '0;
			3: s.watch_bytes = $urandom_range(1, 1 << 20);
			4: s.watch_bytes = $urandom;
			default: s.watch_bytes = $urandom_range(1, 64);
		endcase
		s.raw = $urandom_range(0, 3) == 0;
		return s;
	endfunction

	task automatic put_reg(input asw_pkg::cfg_reg_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			asw_pkg::REG_MIRROR_ENABLE: live.mirror_en = val[asw_pkg::MIRROR_BITS-1:0];
			asw_pkg::REG_TILE_BASE:     live.tile_base = val;
			asw_pkg::REG_HEAP_BASE:     live.heap_base = val;
			asw_pkg::REG_HEAP_OFFSET:   live.heap_offset = val;
			asw_pkg::REG_HEAP_SPAN:     live.heap_span = val;
			asw_pkg::REG_WATCH_START:   live.watch_start = val;
			asw_pkg::REG_WATCH_BYTES:   live.watch_bytes = val;
			asw_pkg::REG_RAW_MODE:      live.raw = val[0];
			default: begin
			end
		endcase
	endtask

	task automatic apply_settings(input settings_t s);
		put_reg(asw_pkg::REG_MIRROR_ENABLE, {{(32 - asw_pkg::MIRROR_BITS){1'b0}}, s.mirror_en});
		put_reg(asw_pkg::REG_TILE_BASE, s.tile_base);
		put_reg(asw_pkg::REG_HEAP_BASE, s.heap_base);
		put_reg(asw_pkg::REG_HEAP_OFFSET, s.heap_offset);
		put_reg(asw_pkg::REG_HEAP_SPAN, s.heap_span);
		put_reg(asw_pkg::REG_WATCH_START, s.watch_start);
		put_reg(asw_pkg::REG_WATCH_BYTES, s.watch_bytes);
		put_reg(asw_pkg::REG_RAW_MODE, {31'd0, s.raw});
		cfg_valid <= 1'b0;
	endtask

	task automatic feed(input write_word_t w);
		pending_writes.push_back(w);
		issued++;
	endtask

	// block is idle once every issued word was taken and reported
	task automatic settle();
		do @(posedge clk); while (taken_count != issued || seen_count != taken_count);
	endtask

	task automatic check_field(input string name, input logic [32:0] exp_v, got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			faults++;
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				due_reports.push_back(judge_write(offered));
				taken_count++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (jitter && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else if (pending_writes.size() > 0) begin
					offered = pending_writes.pop_front();
					in_valid <= 1'b1;
					command <= offered.command;
					address <= offered.address;
					access_bytes <= offered.access_bytes;
					block_length <= offered.block_length;
					writer_function <= offered.writer_function;
					writer_pc <= offered.writer_pc;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and scoreboard
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_reports.size() == 0) begin
					$error("report word with nothing outstanding");
					faults++;
				end else begin
					want = due_reports.pop_front();
					check_field("hit", 33'(want.hit), 33'(hit));
					check_field("compared_address", 33'(want.compared_address),
						33'(compared_address));
					check_field("was_normalized", 33'(want.was_normalized),
						33'(was_normalized));
					check_field("span_low", 33'(want.span_low), 33'(span_low));
					check_field("span_high", want.span_high, span_high);
					check_field("hit_function", 33'(want.hit_function), 33'(hit_function));
					check_field("hit_pc", 33'(want.hit_pc), 33'(hit_pc));
					seen_count++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!long_hold_done && seen_count >= 500) begin
				// back up the pipe so the input side stalls
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (jitter && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		settings_t s;
		int k;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: watch disarmed
		feed(mk(asw_pkg::CMD_STORE, 32'h0000_0000, 4'd1, 32'd0));
		feed(mk(asw_pkg::CMD_BLOCK, 32'h0000_0010, 4'd0, 32'd8));
		settle();

		s.mirror_en = 28'h000_0005;
		s.tile_base = 32'h8000_0000;
		s.heap_base = 32'hC000_0000;
		s.heap_offset = 32'h0000_0F00;
		s.heap_span = 32'h0000_1000;
		s.watch_start = 32'h0000_1000;
		s.watch_bytes = 32'h0000_0010;
		s.raw = 1'b0;
		apply_settings(s);
		feed(mk(asw_pkg::CMD_STORE, 32'h0000_0FFF, 4'd1, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h0000_1000, 4'd1, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h0000_0FFF, 4'd2, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h0000_100F, 4'd8, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h0000_1000, 4'd0, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h0000_1000, 4'd3, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h0400_1000, 4'd4, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h0800_1000, 4'd4, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h0C00_1004, 4'd2, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h03FF_FFFE, 4'd4, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h8000_1008, 4'd8, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'hC000_0100, 4'd4, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'hC000_0FFE, 4'd4, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'hFFFF_FFFC, 4'd8, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'hFFFF_FFFF, 4'd1, 32'd0));
		feed(mk(asw_pkg::CMD_BLOCK, 32'h0000_1008, 4'd0, 32'd0));
		feed(mk(asw_pkg::CMD_BLOCK, 32'h0000_1008, 4'd0, 32'd4));
		feed(mk(asw_pkg::CMD_BLOCK, 32'h0000_0010, 4'd0, 32'h100));
		feed(mk(asw_pkg::CMD_BLOCK, 32'hFFFF_FFFF, 4'd0, 32'hFFFF_FFFF));
		feed(mk(asw_pkg::CMD_BLOCK, 32'h0400_0000, 4'd0, 32'd8));
		settle();

		s.raw = 1'b1;
		apply_settings(s);
		feed(mk(asw_pkg::CMD_STORE, 32'h0000_1000, 4'd4, 32'd0));
		feed(mk(asw_pkg::CMD_STORE, 32'h0400_1000, 4'd4, 32'd0));
		feed(mk(asw_pkg::CMD_BLOCK, 32'h0400_1008, 4'd0, 32'd4));
		settle();

		for (k = 0; k < 11; k++) begin
			case (k)
				0: s = '0;
				1: s = '1;
				2: begin
					s = '1;
					s.raw = 1'b0;
				end
				default: s = random_settings();
			endcase
			jitter = k == 10 ? 1'b0 : $urandom_range(0, 3) != 0;
			apply_settings(s);
			repeat (150) feed(random_word());
			settle();
		end

		repeat (8) @(posedge clk);
		if (faults == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
